[rtl/core/chacha_pkg.sv]
// chacha_pkg: shared types and constants for the chacha20 stream cipher
// holds the fsm encoding, quarter-step rotate select, register indexes and sigma words
// no dependencies
package chacha_pkg;

  localparam int WORD_W = 32;

  // "expand 32-byte k"
  localparam logic [WORD_W-1:0] SIGMA [4] = '{
    32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574
  };

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY_A    = 3'd0,
    CFG_KEY_B    = 3'd1,
    CFG_KEY_C    = 3'd2,
    CFG_KEY_D    = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5,
    CFG_COUNTER  = 3'd6
  } cfg_idx_t;

  // rotate amount of each quarter-round step, in step order
  typedef enum logic [1:0] {
    ROT16 = 2'd0,
    ROT12 = 2'd1,
    ROT8  = 2'd2,
    ROT7  = 2'd3
  } rot_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_PERM  = 5'b00100,
    ST_FEED  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

[rtl/core/chacha_qstep.sv]
// chacha_qstep: one add-xor-rotate step of the chacha quarter round
// also serves the final feed-forward add through its sum output
// depends on chacha_pkg
module chacha_qstep (
  input  logic [chacha_pkg::WORD_W-1:0] x,
  input  logic [chacha_pkg::WORD_W-1:0] y,
  input  logic [chacha_pkg::WORD_W-1:0] z,
  input  chacha_pkg::rot_t              rot,
  output logic [chacha_pkg::WORD_W-1:0] sum,
  output logic [chacha_pkg::WORD_W-1:0] mix
);

  logic [chacha_pkg::WORD_W-1:0] t;

  assign sum = x + y;
  assign t   = z ^ sum;

  always_comb begin
    case (rot)
      chacha_pkg::ROT16: mix = {t[15:0], t[31:16]};
      chacha_pkg::ROT12: mix = {t[19:0], t[31:20]};
      chacha_pkg::ROT8:  mix = {t[23:0], t[31:24]};
      chacha_pkg::ROT7:  mix = {t[24:0], t[31:25]};
      default:           mix = t;
    endcase
  end

endmodule

[rtl/core/chacha20_stream_cipher.sv]
// chacha20_stream_cipher: top level of the byte-serial chacha20 cipher
// sequencer, state words and configuration registers; depends on chacha_pkg
// and chacha_qstep
//
// usage
//   cfg channel (cfg_valid/cfg_ready, always ready): one transfer writes the
//   register at cfg_index with cfg_data; key, nonce and counter take effect
//   from the next keystream block, a counter write also reloads the running
//   block counter. write only while the cipher is idle.
//   item channel (item_valid/item_stall): one transfer carries a byte and its
//   end-of-message flag. result channel (result_valid/result_stall): one
//   transfer carries the byte xored with the keystream.
// timing
//   mid-block byte: result registered in the cycle after the transfer, so one
//   byte per cycle while the receiver keeps up.
//   first byte of a block: the block is computed first, by the single
//   add-xor-rotate unit doing one quarter-round step a cycle, a permute step
//   per half round, 16 feed-forward adds and an emit step.
// reset clears the configuration, the block counter and the byte position.
// a stalled result holds in the output register; no new byte is taken until
// that register can be overwritten.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_in,
  input  logic        end_of_message,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_out
);

  localparam int DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  // configuration
  logic [31:0] key_w [8];
  logic [31:0] nonce_w [3];
  logic [31:0] block_counter;

  // working words; hold the keystream once the block is finished
  logic [31:0] w [16];
  logic [31:0] init_words [16];
  logic [31:0] upd [16];

  chacha_pkg::state_t state;
  logic [5:0]     byte_position;
  logic [3:0]     qcnt;          // {quarter, step} in rounds, word index in feed-forward
  logic           diag_half;
  logic [DrW-1:0] dr;
  logic [7:0]     data_hold;
  logic           eom_hold;

  logic [31:0]      unit_x, unit_y, unit_z, unit_sum, unit_mix;
  chacha_pkg::rot_t unit_rot;
  logic [1:0]       step;
  logic             out_free, accept, emit, block_end, emit_eom;
  logic [7:0]       emit_byte;

  assign cfg_ready = 1'b1;

  // initial block state
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_words[i] = chacha_pkg::SIGMA[i];
    end
    for (int i = 0; i < 8; i++) begin
      init_words[4 + i] = key_w[i];
    end
    init_words[12] = block_counter;
    init_words[13] = nonce_w[0];
    init_words[14] = nonce_w[1];
    init_words[15] = nonce_w[2];
  end

  // handshakes
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == chacha_pkg::ST_IDLE) && out_free);
  assign accept     = item_valid && !item_stall;
  assign emit_byte  = (state == chacha_pkg::ST_IDLE) ? data_in : data_hold;
  assign emit_eom   = (state == chacha_pkg::ST_IDLE) ? end_of_message : eom_hold;
  assign emit       = (accept && (byte_position != 6'd0))
                      || ((state == chacha_pkg::ST_EMIT) && out_free);
  assign block_end  = emit && ((byte_position == 6'd63) || emit_eom);

  // shared step unit: column 0 of the word array holds the active quarter
  assign step     = qcnt[1:0];
  assign unit_rot = chacha_pkg::rot_t'(step);

  always_comb begin
    unit_x = w[0];
    unit_y = init_words[qcnt];
    unit_z = '0;
    if (state == chacha_pkg::ST_ROUND) begin
      if (!step[0]) begin
        unit_x = w[0];
        unit_y = w[4];
        unit_z = w[12];
      end else begin
        unit_x = w[8];
        unit_y = w[12];
        unit_z = w[4];
      end
    end
  end

  chacha_qstep u_qstep (
    .x   (unit_x),
    .y   (unit_y),
    .z   (unit_z),
    .rot (unit_rot),
    .sum (unit_sum),
    .mix (unit_mix)
  );

  // a += b, d = rotl(d ^ a) on even steps; c += d, b = rotl(b ^ c) on odd
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      upd[i] = w[i];
    end
    if (!step[0]) begin
      upd[0]  = unit_sum;
      upd[12] = unit_mix;
    end else begin
      upd[8] = unit_sum;
      upd[4] = unit_mix;
    end
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= chacha_pkg::ST_IDLE;
      result_valid  <= 1'b0;
      byte_position <= '0;
      block_counter <= '0;
      qcnt          <= '0;
      diag_half     <= 1'b0;
      dr            <= '0;
      for (int i = 0; i < 8; i++) begin
        key_w[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        nonce_w[i] <= '0;
      end
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (emit) begin
        byte_position <= block_end ? 6'd0 : byte_position + 6'd1;
      end

      if (cfg_valid && (chacha_pkg::cfg_idx_t'(cfg_index) == chacha_pkg::CFG_COUNTER)) begin
        block_counter <= cfg_data[31:0];
      end else if (block_end) begin
        block_counter <= block_counter + 32'd1;
      end

      if (cfg_valid) begin
        case (chacha_pkg::cfg_idx_t'(cfg_index))
          chacha_pkg::CFG_KEY_A: begin
            key_w[0] <= cfg_data[31:0];
            key_w[1] <= cfg_data[63:32];
          end
          chacha_pkg::CFG_KEY_B: begin
            key_w[2] <= cfg_data[31:0];
            key_w[3] <= cfg_data[63:32];
          end
          chacha_pkg::CFG_KEY_C: begin
            key_w[4] <= cfg_data[31:0];
            key_w[5] <= cfg_data[63:32];
          end
          chacha_pkg::CFG_KEY_D: begin
            key_w[6] <= cfg_data[31:0];
            key_w[7] <= cfg_data[63:32];
          end
          chacha_pkg::CFG_NONCE_LO: begin
            nonce_w[0] <= cfg_data[31:0];
            nonce_w[1] <= cfg_data[63:32];
          end
          chacha_pkg::CFG_NONCE_HI: begin
            nonce_w[2] <= cfg_data[31:0];
          end
          default: begin
          end
        endcase
      end

      case (state)
        chacha_pkg::ST_IDLE: begin
          if (accept && (byte_position == 6'd0)) begin
            state     <= chacha_pkg::ST_ROUND;
            qcnt      <= '0;
            diag_half <= 1'b0;
            dr        <= '0;
          end
        end
        chacha_pkg::ST_ROUND: begin
          qcnt <= qcnt + 4'd1;
          if (qcnt == 4'd15) begin
            state <= chacha_pkg::ST_PERM;
          end
        end
        chacha_pkg::ST_PERM: begin
          if (!diag_half) begin
            diag_half <= 1'b1;
            state     <= chacha_pkg::ST_ROUND;
          end else begin
            diag_half <= 1'b0;
            if (dr == DrW'(DOUBLE_ROUNDS - 1)) begin
              state <= chacha_pkg::ST_FEED;
            end else begin
              dr    <= dr + DrW'(1);
              state <= chacha_pkg::ST_ROUND;
            end
          end
        end
        chacha_pkg::ST_FEED: begin
          qcnt <= qcnt + 4'd1;
          if (qcnt == 4'd15) begin
            state <= chacha_pkg::ST_EMIT;
          end
        end
        chacha_pkg::ST_EMIT: begin
          if (out_free) begin
            state <= chacha_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= chacha_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload: held byte, result byte and the word array
  always_ff @(posedge clk) begin
    if (accept) begin
      data_hold <= data_in;
      eom_hold  <= end_of_message;
    end

    if (emit) begin
      data_out <= emit_byte ^ w[0][7:0];
    end

    if (emit) begin
      // keystream leaves byte by byte from the bottom of word 0
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i + 1][7:0], w[i][31:8]};
      end
      w[15] <= {8'h00, w[15][31:8]};
    end else begin
      case (state)
        chacha_pkg::ST_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 16; i++) begin
              w[i] <= init_words[i];
            end
          end
        end
        chacha_pkg::ST_ROUND: begin
          // after the last step of a quarter, rotate each row left by one word
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              if (step == 2'd3) begin
                w[r * 4 + c] <= upd[r * 4 + ((c + 1) % 4)];
              end else begin
                w[r * 4 + c] <= upd[r * 4 + c];
              end
            end
          end
        end
        chacha_pkg::ST_PERM: begin
          // diagonals into columns, or back
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              if (!diag_half) begin
                w[r * 4 + c] <= w[r * 4 + ((c + r) % 4)];
              end else begin
                w[r * 4 + c] <= w[r * 4 + ((c + 4 - r) % 4)];
              end
            end
          end
        end
        chacha_pkg::ST_FEED: begin
          // rotate through the adder, adding the initial word
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= unit_sum;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
